FILE: sv/nprf_pkg.sv
// shared types and constants for the cubic root finder
package nprf_pkg;

    localparam int START_POINTS = 6;
    localparam int IDX_W = 6;
    localparam int KCNT_W = $clog2(START_POINTS + 1);

    localparam logic [2:0] CFG_CUBIC  = 3'd0;
    localparam logic [2:0] CFG_SQUARE = 3'd1;
    localparam logic [2:0] CFG_LINEAR = 3'd2;
    localparam logic [2:0] CFG_CONST  = 3'd3;
    localparam logic [2:0] CFG_TOL    = 3'd4;
    localparam logic [2:0] CFG_MAXIT  = 3'd5;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_STEP,
        OP_START,
        OP_NEXTK,
        OP_P_INIT,
        OP_P_MUL,
        OP_DP_INIT,
        OP_DP_MUL,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_UPDATE,
        OP_FAIL
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP,
        ST_START,
        ST_P_INIT,
        ST_P_MUL,
        ST_DP_INIT,
        ST_DP_MUL,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_EMIT,
        ST_WAIT
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] sub;
    } cmd_t;

    typedef struct packed {
        logic den_zero;
        logic div_done;
        logic converged;
        logic limit_hit;
        logic last_start;
        logic out_busy;
    } status_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

FILE: sv/nprf_ctrl.sv
// sequencer for start points, polynomial evaluation and division
module nprf_ctrl
    import nprf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic [1:0] sub_reg, sub_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sub_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            sub_reg   <= sub_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sub_next   = sub_reg;
        in_ready   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.sub    = sub_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_STEP;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                // step size is ready in the cycle after capture
                cmd.op     = OP_START;
                state_next = ST_START;
            end
            ST_START:
            begin
                if (status.limit_hit)
                    state_next = ST_EMIT;
                else
                    state_next = ST_P_INIT;
            end
            ST_P_INIT:
            begin
                cmd.op     = OP_P_INIT;
                sub_next   = 2'd0;
                state_next = ST_P_MUL;
            end
            ST_P_MUL:
            begin
                cmd.op   = OP_P_MUL;
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd2)
                    state_next = ST_DP_INIT;
            end
            ST_DP_INIT:
            begin
                cmd.op     = OP_DP_INIT;
                sub_next   = 2'd0;
                state_next = ST_DP_MUL;
            end
            ST_DP_MUL:
            begin
                cmd.op   = OP_DP_MUL;
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd1)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.den_zero)
                begin
                    cmd.op     = OP_FAIL;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.op     = OP_DIV_INIT;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (status.div_done)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.op = OP_UPDATE;
                if (status.converged || status.limit_hit)
                    state_next = ST_EMIT;
                else
                    state_next = ST_P_INIT;
            end
            ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.op = OP_NEXTK;
                    if (status.last_start)
                        state_next = ST_WAIT;
                    else
                        state_next = ST_START;
                end
            end
            ST_WAIT:
            begin
                if (!status.out_busy)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/nprf_dp.sv
// datapath: config registers, horner evaluation, serial divider, result register
module nprf_dp
    import nprf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [30:0]         cfg_data,
    input  logic signed [15:0]  range_low,
    input  logic signed [15:0]  range_high,
    input  cmd_t                cmd,
    output status_t             status,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [IDX_W-1:0]    start_index,
    output logic                found,
    output logic signed [31:0]  root_value,
    output logic [7:0]          iterations_used,
    output logic                last_result
);

    logic signed [15:0] cubic_reg, square_reg, linear_reg, const_reg;
    logic [30:0]        tol_reg;
    logic [7:0]         maxit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cubic_reg  <= 16'sd1;
            square_reg <= 16'sd0;
            linear_reg <= -16'sd4;
            const_reg  <= -16'sd5;
            tol_reg    <= 31'd1;
            maxit_reg  <= 8'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CUBIC:  cubic_reg  <= cfg_data[15:0];
                CFG_SQUARE: square_reg <= cfg_data[15:0];
                CFG_LINEAR: linear_reg <= cfg_data[15:0];
                CFG_CONST:  const_reg  <= cfg_data[15:0];
                CFG_TOL:    tol_reg    <= cfg_data;
                CFG_MAXIT:  maxit_reg  <= cfg_data[7:0];
                default:    ;
            endcase
        end
    end

    // request capture and step size
    logic signed [15:0] lo_reg, hi_reg;
    logic signed [17:0] s_reg;
    logic signed [31:0] x_reg, acc_reg, num_reg, den_reg;
    logic [KCNT_W-1:0]  k_reg;
    logic [7:0]         it_reg;
    logic               found_reg;
    logic signed [31:0] root_reg;

    // floor divide by the start count plus one, via reciprocal multiply and a one-step correction
    logic signed [17:0] diff_w;
    logic signed [17:0] s_w;
    assign diff_w = 18'(hi_reg) - 18'(lo_reg);
    always_comb
    begin
        logic signed [35:0] t;
        t   = diff_w * 18'(((1 << 17) + START_POINTS) / (START_POINTS + 1));
        s_w = 18'(t >>> 17);
        if (diff_w - s_w * 18'(START_POINTS + 1) >= 18'(START_POINTS + 1))
            s_w = s_w + 18'sd1;
        else if (diff_w - s_w * 18'(START_POINTS + 1) < 0)
            s_w = s_w - 18'sd1;
    end

    // start point
    logic signed [63:0] x0_w;
    assign x0_w = (64'(lo_reg) + 64'(k_reg) * 64'(s_reg)) * 64'sd65536;

    // one horner multiply
    logic signed [63:0] prod_w, coef_w, step_w;
    assign prod_w = (64'(acc_reg) * 64'(x_reg)) >>> 16;
    always_comb
    begin
        coef_w = 64'sd0;
        if (cmd.op == OP_P_MUL)
        begin
            case (cmd.sub)
                2'd0:    coef_w = 64'(square_reg) * 64'sd65536;
                2'd1:    coef_w = 64'(linear_reg) * 64'sd65536;
                default: coef_w = 64'(const_reg) * 64'sd65536;
            endcase
        end
        else
        begin
            case (cmd.sub)
                2'd0:    coef_w = 64'(square_reg) * 64'sd131072;
                default: coef_w = 64'(linear_reg) * 64'sd65536;
            endcase
        end
        step_w = 64'(sat32(prod_w)) + coef_w;
    end

    // restoring divider on magnitudes: |num|*2^16 / |den|
    logic [47:0] dvd_reg;
    logic [31:0] dvs_reg;
    logic [31:0] rem_reg;
    logic [5:0]  dcnt_reg;
    logic        qneg_reg;
    logic [32:0] rem_sh, rem_sub;
    assign rem_sh  = {rem_reg, dvd_reg[47]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    logic signed [63:0] q_full, xn_w, dstep;
    logic signed [31:0] xn_sat;
    always_comb
    begin
        q_full = qneg_reg ? -$signed({16'd0, dvd_reg}) : $signed({16'd0, dvd_reg});
        xn_w   = 64'(x_reg) - 64'(sat32(q_full));
        xn_sat = sat32(xn_w);
        dstep  = 64'(xn_sat) - 64'(x_reg);
        if (dstep < 0)
            dstep = -dstep;
    end

    // output register
    logic out_valid_reg;
    logic [IDX_W-1:0] oidx_reg;
    logic ofound_reg, olast_reg;
    logic signed [31:0] oroot_reg;
    logic [7:0] oit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_NEXTK)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_NEXTK)
        begin
            oidx_reg   <= IDX_W'(k_reg);
            ofound_reg <= found_reg;
            oroot_reg  <= found_reg ? root_reg : 32'sd0;
            oit_reg    <= it_reg;
            olast_reg  <= (k_reg == KCNT_W'(START_POINTS - 1));
        end
        case (cmd.op)
            OP_STEP:
            begin
                lo_reg <= range_low;
                hi_reg <= range_high;
                k_reg  <= '0;
            end
            OP_START:
            begin
                s_reg     <= s_w;
                x_reg     <= sat32(x0_w);
                it_reg    <= 8'd0;
                found_reg <= 1'b0;
            end
            OP_NEXTK:
            begin
                k_reg     <= k_reg + KCNT_W'(1);
                x_reg     <= sat32((64'(lo_reg) + 64'(k_reg + KCNT_W'(1)) * 64'(s_reg))
                                   * 64'sd65536);
                it_reg    <= 8'd0;
                found_reg <= 1'b0;
            end
            OP_P_INIT:
            begin
                acc_reg <= sat32(64'(cubic_reg) * 64'sd65536);
                it_reg  <= it_reg + 8'd1;
            end
            OP_P_MUL:
            begin
                acc_reg <= sat32(step_w);
                if (cmd.sub == 2'd2)
                    num_reg <= sat32(step_w);
            end
            OP_DP_INIT:
            begin
                acc_reg <= sat32(64'(cubic_reg) * 64'sd196608);
            end
            OP_DP_MUL:
            begin
                acc_reg <= sat32(step_w);
                if (cmd.sub == 2'd1)
                    den_reg <= sat32(step_w);
            end
            OP_DIV_INIT:
            begin
                dvd_reg  <= {(num_reg < 0) ? 32'(-64'(num_reg)) : 32'(num_reg), 16'd0};
                dvs_reg  <= (den_reg < 0) ? 32'(-64'(den_reg)) : 32'(den_reg);
                qneg_reg <= (num_reg < 0) ^ (den_reg < 0);
                rem_reg  <= '0;
                dcnt_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                if (dcnt_reg != 6'd48)
                begin
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (!rem_sub[32])
                    begin
                        rem_reg <= rem_sub[31:0];
                        dvd_reg <= {dvd_reg[46:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh[31:0];
                        dvd_reg <= {dvd_reg[46:0], 1'b0};
                    end
                end
            end
            OP_UPDATE:
            begin
                x_reg <= xn_sat;
                if (dstep < 64'(tol_reg))
                begin
                    found_reg <= 1'b1;
                    root_reg  <= xn_sat;
                end
            end
            default: ;
        endcase
    end

    assign status.den_zero   = (den_reg == 32'sd0);
    assign status.div_done   = (dcnt_reg == 6'd48);
    assign status.converged  = (dstep < 64'(tol_reg));
    assign status.limit_hit  = (it_reg >= maxit_reg);
    assign status.last_start = (k_reg == KCNT_W'(START_POINTS - 1));
    assign status.out_busy   = out_valid_reg && !out_ready;

    assign out_valid       = out_valid_reg;
    assign start_index     = oidx_reg;
    assign found           = ofound_reg;
    assign root_value      = oroot_reg;
    assign iterations_used = oit_reg;
    assign last_result     = olast_reg;

endmodule

FILE: sv/newton_polynomial_root_finder.sv
// top level of the newton cubic root finder
//
// input channel: in_valid / in_ready carries one request, an integer search
// interval range_low..range_high. a request is taken only while the block is
// idle; it then runs START_POINTS start points one after another.
// output channel: out_valid / out_ready carries one result per start point,
// in start order; last_result marks the final one.
// each newton iteration evaluates p(x) and then p'(x), runs a check step,
// steps the bit-serial divider and ends with an update step. the divider
// takes the largest share of the time. an iteration that meets a zero
// slope ends after its evaluation and check steps.
// a result sits in an output register; when the receiver stalls, the
// sequencer waits in its emit step before starting the next start point.
// the config port (cfg_we, cfg_index, cfg_data) writes one register a cycle
// and should be used only while idle.
// reset clears the sequencer and output valid and loads the default cubic
// x^3 - 4x - 5 with tolerance 2^-16 and ten iterations.
module newton_polynomial_root_finder
    import nprf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [30:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  range_low,
    input  logic signed [15:0]  range_high,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [IDX_W-1:0]    start_index,
    output logic                found,
    output logic signed [31:0]  root_value,
    output logic [7:0]          iterations_used,
    output logic                last_result
);

    cmd_t    cmd;
    status_t status;

    // sequencer
    nprf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and result register
    nprf_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .range_low       (range_low),
        .range_high      (range_high),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .start_index     (start_index),
        .found           (found),
        .root_value      (root_value),
        .iterations_used (iterations_used),
        .last_result     (last_result)
    );

endmodule

FILE: sv/nprf_checker.sv
// port-level checks for the root finder
module nprf_checker
    import nprf_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic                found,
    input logic signed [31:0]  root_value,
    input logic [7:0]          iterations_used
);

    // no new request while a result is pending
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request taken with result pending");

    // a not-found result carries a zero root
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (root_value == 32'sd0))
        else $error("not-found result with nonzero root");

    // a found result used at least one iteration
    a_iter: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (iterations_used != 8'd0))
        else $error("found with zero iterations");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(root_value)))
        else $error("stalled result changed");

    // a waiting request stays offered
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_ready) |=> in_valid)
        else $error("request withdrawn before acceptance");

endmodule

bind newton_polynomial_root_finder nprf_checker u_nprf_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .found           (found),
    .root_value      (root_value),
    .iterations_used (iterations_used)
);

FILE: tb/tb_newton_polynomial_root_finder.sv
// testbench for the newton cubic root finder: directed and random requests checked against a predictor
`timescale 1ns / 1ps

module tb_newton_polynomial_root_finder;
    import nprf_pkg::*;

    // one result of a start point
    typedef struct packed {
        logic [IDX_W-1:0]    idx;
        logic                fnd;
        logic signed [31:0]  root;
        logic [7:0]          iters;
        logic                last;
    } root_rec_t;

    localparam int WATCHDOG_LIMIT = 200000;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [2:0]          cfg_index;
    logic [30:0]         cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic signed [15:0]  range_low;
    logic signed [15:0]  range_high;
    logic                out_valid;
    logic                out_ready;
    logic [IDX_W-1:0]    start_index;
    logic                found;
    logic signed [31:0]  root_value;
    logic [7:0]          iterations_used;
    logic                last_result;

    newton_polynomial_root_finder dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .range_low(range_low), .range_high(range_high),
        .out_valid(out_valid), .out_ready(out_ready),
        .start_index(start_index), .found(found), .root_value(root_value),
        .iterations_used(iterations_used), .last_result(last_result)
    );

    // predictor copy of the config registers
    logic signed [15:0] m_cubic, m_square, m_linear, m_const;
    logic [30:0]        m_tol;
    logic [7:0]         m_maxit;

    root_rec_t expected_roots[$];
    int  errors;
    int  requests_sent;
    int  results_seen;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    int  idle_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // saturate a wide value to q16.16
    function automatic longint qsat(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // floor division, matches the block's rounding toward minus infinity
    function automatic longint floor_div(input longint a, input longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && ((a < 0) != (d < 0)))
            q = q - 1;
        return q;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return qsat(floor_div(a * b, 65536));
    endfunction

    function automatic longint poly_at(input longint x);
        longint acc;
        acc = qsat(longint'(m_cubic) * 65536);
        acc = qsat(qmul(acc, x) + longint'(m_square) * 65536);
        acc = qsat(qmul(acc, x) + longint'(m_linear) * 65536);
        acc = qsat(qmul(acc, x) + longint'(m_const) * 65536);
        return acc;
    endfunction

    function automatic longint slope_at(input longint x);
        longint acc;
        acc = qsat(3 * longint'(m_cubic) * 65536);
        acc = qsat(qmul(acc, x) + 2 * longint'(m_square) * 65536);
        acc = qsat(qmul(acc, x) + longint'(m_linear) * 65536);
        return acc;
    endfunction

    // run every start point of one request and queue its results
    task automatic predict_roots(input logic signed [15:0] lo, input logic signed [15:0] hi);
        longint    step, x, xn, num, den, diff, root;
        int        it;
        bit        ok;
        root_rec_t r;
        step = floor_div(longint'(hi) - longint'(lo), START_POINTS + 1);
        for (int k = 0; k < START_POINTS; k++)
        begin
            x = qsat((longint'(lo) + k * step) * 65536);
            it = 0;
            ok = 0;
            root = 0;
            while (it < m_maxit && !ok)
            begin
                it++;
                num = poly_at(x);
                den = slope_at(x);
                if (den == 0)
                    break;
                xn = qsat(x - qsat((num * 65536) / den));
                diff = (xn > x) ? xn - x : x - xn;
                if (diff < longint'(m_tol))
                begin
                    ok = 1;
                    root = xn;
                end
                x = xn;
            end
            r.idx = k[IDX_W-1:0];
            r.fnd = ok;
            r.root = root[31:0];
            r.iters = it[7:0];
            r.last = (k == START_POINTS - 1);
            expected_roots.push_back(r);
        end
    endtask

    // config write, only while the block is idle
    task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CUBIC:  m_cubic = val[15:0];
            CFG_SQUARE: m_square = val[15:0];
            CFG_LINEAR: m_linear = val[15:0];
            CFG_CONST:  m_const = val[15:0];
            CFG_TOL:    m_tol = val;
            CFG_MAXIT:  m_maxit = val[7:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_poly(input int c3, input int c2, input int c1, input int c0);
        write_reg(CFG_CUBIC, 31'(c3 & 16'hffff));
        write_reg(CFG_SQUARE, 31'(c2 & 16'hffff));
        write_reg(CFG_LINEAR, 31'(c1 & 16'hffff));
        write_reg(CFG_CONST, 31'(c0 & 16'hffff));
    endtask

    // offer one request, hold it until accepted
    task automatic send_request(input logic signed [15:0] lo, input logic signed [15:0] hi);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        in_valid <= 1'b1;
        range_low <= lo;
        range_high <= hi;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_roots(lo, hi);
        requests_sent++;
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every result is back, then let the sequencer settle
    task automatic drain;
        int guard;
        guard = 0;
        while (expected_roots.size() != 0)
            @(posedge clk);
        while (guard < 200)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    // receiver readiness, with an optional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (recv_hold)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        root_rec_t e;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_roots.size() == 0)
            begin
                $error("unexpected result start_index=%0d", start_index);
                errors++;
            end
            else
            begin
                e = expected_roots.pop_front();
                if (start_index !== e.idx)
                begin
                    $error("start_index exp %0d got %0d", e.idx, start_index);
                    errors++;
                end
                if (found !== e.fnd)
                begin
                    $error("found exp %0d got %0d", e.fnd, found);
                    errors++;
                end
                if (root_value !== e.root)
                begin
                    $error("root_value exp %0d got %0d", e.root, root_value);
                    errors++;
                end
                if (iterations_used !== e.iters)
                begin
                    $error("iterations_used exp %0d got %0d", e.iters, iterations_used);
                    errors++;
                end
                if (last_result !== e.last)
                begin
                    $error("last_result exp %0d got %0d", e.last, last_result);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // default cubic x^3 - 4x - 5, edges of the interval fields
    task automatic test_reset_defaults;
        send_request(16'sd0, 16'sd7);
        send_request(16'sd1, 16'sd4);
        send_request(-16'sd32768, 16'sd32767);
        send_request(16'sd32767, -16'sd32768);
        send_request(16'sd5, 16'sd5);
        send_request(-16'sd1, -16'sd1);
        drain();
    endtask

    // zero slope, zero iteration limit, zero tolerance, extreme coefficients
    task automatic test_special_cases;
        set_poly(0, 0, 0, 7);
        send_request(-16'sd10, 16'sd10);
        drain();
        set_poly(1, -3, 3, -1);
        write_reg(CFG_MAXIT, 31'd0);
        send_request(16'sd0, 16'sd14);
        drain();
        write_reg(CFG_MAXIT, 31'd255);
        write_reg(CFG_TOL, 31'd0);
        send_request(-16'sd3, 16'sd3);
        drain();
        write_reg(CFG_TOL, 31'h7fffffff);
        write_reg(CFG_MAXIT, 31'd1);
        set_poly(-32768, 32767, -32768, 32767);
        send_request(-16'sd32768, 16'sd32767);
        send_request(16'sd100, -16'sd100);
        drain();
        set_poly(32767, -32768, 32767, -32768);
        write_reg(CFG_TOL, 31'd655);
        write_reg(CFG_MAXIT, 31'd20);
        send_request(16'sd0, 16'sd0);
        drain();
        // out-of-range register index must be ignored
        write_reg(3'd7, 31'h7fffffff);
        write_reg(3'd6, 31'h0);
        send_request(-16'sd2, 16'sd30);
        drain();
    endtask

    // receiver holds off while requests keep coming
    task automatic test_output_stall;
        int n;
        set_poly(1, 0, -4, -5);
        write_reg(CFG_TOL, 31'd1);
        write_reg(CFG_MAXIT, 31'd10);
        send_idle_pct = 0;
        recv_hold = 1'b1;
        fork
            begin
                n = 0;
                while (n < 3000)
                begin
                    @(posedge clk);
                    n++;
                end
                recv_hold = 1'b0;
            end
            begin
                send_request(16'sd0, 16'sd7);
                send_request(-16'sd5, 16'sd9);
                send_request(16'sd3, -16'sd4);
            end
        join
        drain();
    endtask

    // random requests, coefficients reshuffled between batches
    task automatic test_random(input int count, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i % 10 == 0)
            begin
                drain();
                // mostly small coefficients so roots exist, now and then full range
                if ($urandom_range(3) == 0)
                    set_poly($urandom, $urandom, $urandom, $urandom);
                else
                    set_poly($urandom_range(8) - 4, $urandom_range(16) - 8,
                             $urandom_range(40) - 20, $urandom_range(60) - 30);
                write_reg(CFG_TOL, ($urandom_range(3) == 0) ? 31'($urandom) :
                          31'($urandom_range(1, 2000)));
                write_reg(CFG_MAXIT, ($urandom_range(9) == 0) ? 31'($urandom_range(255)) :
                          31'($urandom_range(1, 12)));
            end
            if ($urandom_range(4) == 0)
                send_request(16'($urandom), 16'($urandom));
            else
                send_request(16'($urandom_range(40) - 20), 16'($urandom_range(40) - 20));
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        range_low = '0;
        range_high = '0;
        errors = 0;
        requests_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        recv_hold = 1'b0;
        send_idle_pct = 28;
        recv_idle_pct = 50;
        m_cubic = 16'sd1;
        m_square = 16'sd0;
        m_linear = -16'sd4;
        m_const = -16'sd5;
        m_tol = 31'd1;
        m_maxit = 8'd10;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_special_cases();
        test_output_stall();
        test_random(60, 28, 50);
        test_random(60, 50, 28);
        test_random(60, 0, 0);

        $display("covered %0d requests and %0d results over default, degenerate and random cubics",
                 requests_sent, results_seen);
        $display("including zero slope, zero limit, zero tolerance and a long receiver stall");
        if (errors == 0 && expected_roots.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
